// ----- hw/rtl/tcch_pkg.sv -----
`default_nettype none
package tcch_pkg;

  // Iteration count and the size of the arctangent table.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CNT_W            = 5;

  // Datapath widths.
  localparam int SC_W   = 34;  // Q30 sine and cosine, rotation angle
  localparam int PRD_W  = 36;  // serial product accumulators
  localparam int MPY_W  = 32;  // serial multiplier length for Q30 factors
  localparam int CNTS_W = 17;  // remapped magnetometer counts
  localparam int MAC_W  = 52;  // horizontal field components
  localparam int VEC_W  = 54;  // vectoring x and y
  localparam int ANG_W  = 34;  // 32-bit binary angle with headroom

  localparam logic signed [SC_W-1:0] CORDIC_GAIN = 34'sd652032875;

  // Configuration register map.
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_MAG_ORIENT = 3'd0;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic               mag_valid;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
  } tcch_in_t;

  typedef struct packed {
    logic signed [15:0] heading_angle;
    logic               heading_new;
  } tcch_out_t;

  // Control of one sine/cosine rotation unit.
  typedef struct packed {
    logic             load;
    logic             step;
    logic             last;
    logic [CNT_W-1:0] idx;
  } tcch_sc_ctl_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [29:0] atan_lut(input logic [CNT_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      5'd20:   v = 30'h0000028C;
      5'd21:   v = 30'h00000146;
      5'd22:   v = 30'h000000A3;
      5'd23:   v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tilt_compensated_compass_heading.sv -----
// Flow for a valid sample: the sine/cosine loop (S_SC), S_PREP, the serial multiply (S_M1),
// the field sum (S_M2), S_VI, the atan2 loop (S_AT, which can end early) and S_DONE;
// a held sample goes straight from S_IDLE to S_DONE.
// One item at a time: no new input beat is taken until the result has been loaded.
// Reset is synchronous: control clears, orientation returns to remap, held heading 0.
`default_nettype none
module tilt_compensated_compass_heading #(
  parameter int CORDIC_STEPS = tcch_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tcch_pkg::tcch_in_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tcch_pkg::tcch_out_t                out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [tcch_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import tcch_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);
  localparam logic [CNT_W-1:0] M1_LAST   = CNT_W'(MPY_W - 1);
  localparam logic [CNT_W-1:0] M1_SHIFTS = CNT_W'(MPY_W - 2);
  localparam logic [CNT_W-1:0] M2_LAST   = CNT_W'(CNTS_W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SC   = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_M1   = 3'd3;
  localparam logic [2:0] S_M2   = 3'd4;
  localparam logic [2:0] S_VI   = 3'd5;
  localparam logic [2:0] S_AT   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   orient_r;
  logic                   new_r;
  logic signed [15:0]     held_r;
  logic                   out_valid_r;
  tcch_out_t              out_data_r;

  logic [CNTS_W-1:0]      bx_r, by_r, bz_r;
  logic [MPY_W-1:0]       sp_sh_r;
  logic signed [PRD_W-1:0] srsp_r, crsp_r, srsp_nxt, crsp_nxt;
  logic signed [MAC_W-1:0] mx_r, my_r, mx_nxt, my_nxt;
  logic signed [VEC_W-1:0] vx_r, vy_r, vx_nxt, vy_nxt;
  logic signed [ANG_W-1:0] vz_r, vz_nxt, vz_fin, vz_rnd;

  logic                   in_acc, out_load, cfg_wr;
  tcch_sc_ctl_t           sc_ctl;
  logic signed [SC_W-1:0] sr, cr, sp, cp;
  logic signed [PRD_W-1:0] tr, tc;
  logic signed [PRD_W-1:0] tx, ty;
  logic signed [ANG_W-1:0] at;
  logic signed [CNTS_W-1:0] nx, nz;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                    (cfg_paddr == ADDR_MAG_ORIENT);

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_MAG_ORIENT) ? {31'd0, orient_r} : 32'd0;

  // Negated X and Z counts for the remapped orientation.
  assign nx = -{in_data.mag_x[15], in_data.mag_x};
  assign nz = -{in_data.mag_z[15], in_data.mag_z};

  // Two rotation units give roll and pitch sine and cosine together.
  always_comb begin
    sc_ctl.load = in_acc;
    sc_ctl.step = (state_r == S_SC);
    sc_ctl.last = (cnt_r == LAST_STEP);
    sc_ctl.idx  = cnt_r;
  end

  tcch_sincos u_roll (
    .clk   (clk),
    .ctl   (sc_ctl),
    .angle (in_data.roll_angle),
    .sin_q (sr),
    .cos_q (cr)
  );

  tcch_sincos u_pitch (
    .clk   (clk),
    .ctl   (sc_ctl),
    .angle (in_data.pitch_angle),
    .sin_q (sp),
    .cos_q (cp)
  );

  // Serial products sin(r)*sin(p) and cos(r)*sin(p), one multiplier bit a cycle.
  // For the low 30 multiplier bits the partial sum shifts right, which floors exactly.
  always_comb begin
    tr = sp_sh_r[0] ? PRD_W'(sr) : '0;
    tc = sp_sh_r[0] ? PRD_W'(cr) : '0;
    if (cnt_r == M1_LAST) begin
      tr = -tr;
      tc = -tc;
    end
    if (cnt_r < M1_SHIFTS) begin
      srsp_nxt = (srsp_r + tr) >>> 1;
      crsp_nxt = (crsp_r + tc) >>> 1;
    end else begin
      srsp_nxt = srsp_r + (tr <<< (cnt_r - M1_SHIFTS));
      crsp_nxt = crsp_r + (tc <<< (cnt_r - M1_SHIFTS));
    end
  end

  // Horizontal field, most significant count bit first; the sign bit weighs negative.
  always_comb begin
    tx = (bx_r[CNTS_W-1] ? PRD_W'(cp) : PRD_W'(0))
       + (by_r[CNTS_W-1] ? srsp_r : PRD_W'(0))
       + (bz_r[CNTS_W-1] ? crsp_r : PRD_W'(0));
    ty = (by_r[CNTS_W-1] ? PRD_W'(cr) : PRD_W'(0))
       - (bz_r[CNTS_W-1] ? PRD_W'(sr) : PRD_W'(0));
    if (cnt_r == '0) begin
      tx = -tx;
      ty = -ty;
    end
    mx_nxt = (mx_r <<< 1) + MAC_W'(tx);
    my_nxt = (my_r <<< 1) + MAC_W'(ty);
  end

  // Vectoring step of atan2 and the final rounding to 16 bits.
  always_comb begin
    at = $signed({{(ANG_W-30){1'b0}}, atan_lut(cnt_r)});
    if (!vy_r[VEC_W-1]) begin
      vx_nxt = vx_r + (vy_r >>> cnt_r);
      vy_nxt = vy_r - (vx_r >>> cnt_r);
      vz_nxt = vz_r + at;
    end else begin
      vx_nxt = vx_r - (vy_r >>> cnt_r);
      vy_nxt = vy_r + (vx_r >>> cnt_r);
      vz_nxt = vz_r - at;
    end
    vz_fin = (vy_r == '0) ? vz_r : vz_nxt;
    vz_rnd = vz_fin + ANG_W'(32768);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = in_data.mag_valid ? S_SC : S_DONE;
        end
      end
      S_SC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == M1_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_M2;
        end
      end
      S_M2: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == M2_LAST) begin
          state_nxt = S_VI;
        end
      end
      S_VI: begin
        cnt_nxt   = '0;
        state_nxt = S_AT;
      end
      S_AT: begin
        cnt_nxt = cnt_r + 1'b1;
        if ((vy_r == '0) || (cnt_r == LAST_STEP)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      orient_r    <= 1'b1;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr) begin
        orient_r <= cfg_pwdata[0];
      end
      if ((state_r == S_AT) && (state_nxt == S_DONE)) begin
        held_r <= vz_rnd[31:16];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      new_r <= in_data.mag_valid;
      if (orient_r) begin
        bx_r <= {in_data.mag_y[15], in_data.mag_y};
        by_r <= nx;
        bz_r <= nz;
      end else begin
        bx_r <= {in_data.mag_x[15], in_data.mag_x};
        by_r <= {in_data.mag_y[15], in_data.mag_y};
        bz_r <= {in_data.mag_z[15], in_data.mag_z};
      end
    end
    unique case (state_r)
      S_PREP: begin
        sp_sh_r <= sp[MPY_W-1:0];
        srsp_r  <= '0;
        crsp_r  <= '0;
        mx_r    <= '0;
        my_r    <= '0;
      end
      S_M1: begin
        sp_sh_r <= sp_sh_r >> 1;
        srsp_r  <= srsp_nxt;
        crsp_r  <= crsp_nxt;
      end
      S_M2: begin
        mx_r <= mx_nxt;
        my_r <= my_nxt;
        bx_r <= bx_r << 1;
        by_r <= by_r << 1;
        bz_r <= bz_r << 1;
      end
      S_VI: begin
        if (mx_r[MAC_W-1]) begin
          vx_r <= -VEC_W'(mx_r);
          vy_r <= -VEC_W'(my_r);
          vz_r <= my_r[MAC_W-1] ? -(ANG_W'(1) <<< 31) : (ANG_W'(1) <<< 31);
        end else begin
          vx_r <= VEC_W'(mx_r);
          vy_r <= VEC_W'(my_r);
          vz_r <= '0;
        end
      end
      S_AT: begin
        if (vy_r != '0) begin
          vx_r <= vx_nxt;
          vy_r <= vy_nxt;
          vz_r <= vz_nxt;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r.heading_angle <= held_r;
      out_data_r.heading_new   <= new_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/tcch_sincos.sv -----
`default_nettype none
module tcch_sincos (
  input  wire logic                             clk,
  input  wire tcch_pkg::tcch_sc_ctl_t           ctl,
  input  wire logic signed [15:0]               angle,
  output logic signed [tcch_pkg::SC_W-1:0]      sin_q,
  output logic signed [tcch_pkg::SC_W-1:0]      cos_q
);
  import tcch_pkg::*;

  logic signed [SC_W-1:0] x_r, y_r, z_r;
  logic signed [SC_W-1:0] x_nxt, y_nxt, z_nxt;
  logic                   neg_r;
  logic signed [16:0]     a_ext, a_fold;
  logic                   fold;
  logic signed [SC_W-1:0] xs, ys, at, xu, yu;

  // Fold the angle into +-90 degrees; the results are negated at the end.
  always_comb begin
    a_ext = {angle[15], angle};
    fold  = (angle > 16'sd16384) || (angle < -16'sd16384);
    if (angle > 16'sd16384) begin
      a_fold = a_ext - 17'sd32768;
    end else if (angle < -16'sd16384) begin
      a_fold = a_ext + 17'sd32768;
    end else begin
      a_fold = a_ext;
    end
  end

  // One rotation step per cycle, driven by the sign of the residual angle.
  always_comb begin
    xs = x_r >>> ctl.idx;
    ys = y_r >>> ctl.idx;
    at = $signed({{(SC_W-30){1'b0}}, atan_lut(ctl.idx)});
    if (!z_r[SC_W-1]) begin
      xu    = x_r - ys;
      yu    = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      xu    = x_r + ys;
      yu    = y_r - xs;
      z_nxt = z_r + at;
    end
    if (ctl.last && neg_r) begin
      x_nxt = -xu;
      y_nxt = -yu;
    end else begin
      x_nxt = xu;
      y_nxt = yu;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= $signed({a_fold[16], a_fold, 16'd0});
      neg_r <= fold;
    end else if (ctl.step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign sin_q = y_r;
  assign cos_q = x_r;

endmodule
`default_nettype wire

// ----- hw/rtl/tcch_checker.sv -----
`default_nettype none
module tcch_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire tcch_pkg::tcch_out_t out_data
);

  // A result beat that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Only one item is in work: after an input beat the block stalls.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tilt_compensated_compass_heading tcch_checker u_tcch_checker (.*);
`default_nettype wire

// ----- bench/tb_tilt_compensated_compass_heading.sv -----
module tb_tilt_compensated_compass_heading;
  import tcch_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int NRAND = 1950;
  localparam int IN_W  = $bits(tcch_in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tcch_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tcch_out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  tilt_compensated_compass_heading DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: a copy of the orientation register and the held heading.
  logic remap_axes;
  logic [15:0] held_pred;
  tcch_out_t heading_q[$];
  int errors = 0;

  longint atan_k[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  // Rotation CORDIC for Q30 sine and cosine of a 16-bit binary angle.
  function automatic void rotate_angle(input longint ang, output longint s,
                                       output longint c);
    longint x, y, z, t;
    bit flip;
    x = 652032875;
    y = 0;
    flip = 0;
    if (ang > 16384 || ang < -16384) begin
      ang = (ang > 0) ? ang - 32768 : ang + 32768;
      flip = 1;
    end
    z = ang * 65536;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_k[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_k[i];
      end
      x = t;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Vectoring CORDIC giving a 32-bit binary angle of atan2(y, x).
  function automatic longint vector_angle(longint y, longint x);
    longint z, t;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_k[i];
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_k[i];
      end
      x = t;
    end
    return z;
  endfunction

  function automatic tcch_out_t predict_heading(tcch_in_t s);
    tcch_out_t r;
    longint bx, by, bz, sr, cr, sp, cp, srsp, crsp, mx, my, z;
    if (!s.mag_valid) begin
      r.heading_angle = held_pred;
      r.heading_new = 1'b0;
      return r;
    end
    if (remap_axes) begin
      bx = longint'(s.mag_y);
      by = -longint'(s.mag_x);
      bz = -longint'(s.mag_z);
    end else begin
      bx = longint'(s.mag_x);
      by = longint'(s.mag_y);
      bz = longint'(s.mag_z);
    end
    rotate_angle(longint'(s.roll_angle), sr, cr);
    rotate_angle(longint'(s.pitch_angle), sp, cp);
    srsp = (sr * sp) >>> 30;
    crsp = (cr * sp) >>> 30;
    mx = bx * cp + by * srsp + bz * crsp;
    my = by * cr - bz * sr;
    z = vector_angle(my, mx);
    held_pred = 16'((z + 32768) >>> 16);
    r.heading_angle = held_pred;
    r.heading_new = 1'b1;
    return r;
  endfunction

  // Receiver: stall pattern and result checking.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[8])
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 3) == 0);
    if (rst_n && out_valid && !out_stall) begin
      if (heading_q.size() == 0) begin
        $error("result beat with nothing expected: heading_angle=%0d", out_data.heading_angle);
        errors++;
      end else begin
        tcch_out_t e;
        e = heading_q.pop_front();
        if (out_data.heading_angle !== e.heading_angle) begin
          $error("heading_angle expected %0d actual %0d", e.heading_angle,
                 out_data.heading_angle);
          errors++;
        end
        if (out_data.heading_new !== e.heading_new) begin
          $error("heading_new expected %0d actual %0d", e.heading_new, out_data.heading_new);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= a;
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (a == ADDR_MAG_ORIENT) remap_axes = d[0];
  endtask

  task automatic drain_results();
    while (heading_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // One input beat; an optional typed-in expectation overrides the predictor.
  task automatic send_sample(input tcch_in_t s, input bit fixed, input tcch_out_t fx);
    tcch_out_t e;
    @(posedge clk);
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = predict_heading(s);
    if (fixed) begin
      e = fx;
      if (fx.heading_new) held_pred = fx.heading_angle;
    end
    heading_q.push_back(e);
    in_valid <= 1'b0;
  endtask

  typedef struct {
    tcch_in_t s;
    bit fixed;
    tcch_out_t r;
  } sample_row_t;

  function automatic tcch_in_t mk(int x, int y, int z, bit v, int r, int p);
    tcch_in_t s;
    s.mag_x = 16'(x); s.mag_y = 16'(y); s.mag_z = 16'(z);
    s.mag_valid = v; s.roll_angle = 16'(r); s.pitch_angle = 16'(p);
    return s;
  endfunction

  function automatic tcch_in_t rand_sample(bit well_formed);
    tcch_in_t s;
    s = tcch_in_t'(IN_W'({$urandom, $urandom, $urandom}));
    if (well_formed) begin
      s.mag_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 1)) begin
        s.roll_angle = 16'($signed($urandom_range(0, 12000)) - 6000);
        s.pitch_angle = 16'($signed($urandom_range(0, 12000)) - 6000);
      end
    end
    return s;
  endfunction

  initial begin
    sample_row_t rows[$];
    tcch_out_t o;
    int burst;
    remap_axes = 1'b1;
    held_pred = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Held sample after reset repeats zero; zero vector gives zero.
    o.heading_new = 1'b0; o.heading_angle = 16'sd0;
    rows.push_back('{mk(1000, 2000, 3000, 0, 0, 0), 1, o});
    o.heading_new = 1'b1; o.heading_angle = 16'sd0;
    rows.push_back('{mk(0, 0, 0, 1, 0, 0), 1, o});
    rows.push_back('{mk(-32768, -32768, -32768, 1, -32768, -32768), 0, o});
    rows.push_back('{mk(32767, 32767, 32767, 1, 32767, 32767), 0, o});
    rows.push_back('{mk(-32768, 0, 0, 1, 0, 0), 0, o});
    rows.push_back('{mk(0, -32768, 0, 1, 0, 0), 0, o});
    rows.push_back('{mk(0, 5, 0, 1, 0, 0), 0, o});
    rows.push_back('{mk(0, -5, 0, 1, 0, 0), 0, o});
    rows.push_back('{mk(1000, 1000, 1000, 1, 16384, -16384), 0, o});
    rows.push_back('{mk(1000, -1000, 500, 1, 16385, -16385), 0, o});
    rows.push_back('{mk(7, 7, 7, 0, 123, 456), 0, o});
    rows.push_back('{mk(-300, 0, 2000, 1, 8000, -8000), 0, o});

    // Directed table under both orientations.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        reg_write(ADDR_MAG_ORIENT, 32'd0);
        rows[0].fixed = 0;
        rows[1].fixed = 0;
      end
      foreach (rows[i]) send_sample(rows[i].s, rows[i].fixed, rows[i].r);
      drain_results();
    end
    reg_write(ADDR_MAG_ORIENT, 32'd1);

    // Random phases in bursts with gaps; orientation set at random between phases.
    for (int ph = 0; ph < 6; ph++) begin
      int n;
      n = NRAND / 6;
      while (n > 0) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && n > 0; k++, n--)
          send_sample(rand_sample($urandom_range(0, 4) != 0), 0, o);
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
      drain_results();
      reg_write(ADDR_MAG_ORIENT, {$urandom} & 32'h1);
    end

    drain_results();
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #30000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/tcch_pkg.sv
hw/rtl/tcch_sincos.sv
hw/rtl/tilt_compensated_compass_heading.sv
hw/rtl/tcch_checker.sv
bench/tb_tilt_compensated_compass_heading.sv
